// ===== rtl/kbms_pkg.sv =====
// kbms_pkg: shared constants, key code table and helpers for the key matrix scanner.
// No dependencies; used by keyboard_matrix_scanner.
`default_nettype none

package kbms_pkg;

  localparam int unsigned NumRows  = 7;
  localparam int unsigned NumCols  = 8;
  localparam int unsigned NumKeys  = NumRows * NumCols;
  localparam int unsigned CodeW    = 8;
  localparam int unsigned EntropyW = 16;
  localparam int unsigned CfgIdxW  = 3;

  typedef logic [CodeW-1:0]    code_t;
  typedef logic [EntropyW-1:0] entropy_t;
  typedef logic [NumKeys-1:0]  matrix_t;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_UP     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_DOWN   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_DELETE = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_RETURN = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_ESCAPE = 3'd4;

  localparam code_t RST_UP     = 8'd145;
  localparam code_t RST_DOWN   = 8'd17;
  localparam code_t RST_DELETE = 8'd20;
  localparam code_t RST_RETURN = 8'd13;
  localparam code_t RST_ESCAPE = 8'd27;

  // Matrix bit positions of special keys
  localparam int unsigned KEY_UP     = 27;
  localparam int unsigned KEY_DOWN   = 28;
  localparam int unsigned KEY_DELETE = 29;
  localparam int unsigned KEY_RETURN = 48;
  localparam int unsigned KEY_ESCAPE = 50;
  localparam int unsigned KEY_SHIFT  = 55;

  localparam code_t CODE_COLON = 8'd58;
  localparam code_t CODE_SEMI  = 8'd59;
  localparam code_t CODE_MINUS = 8'd45;
  localparam code_t CODE_STAR  = 8'd42;
  localparam code_t CODE_PLUS  = 8'd43;
  localparam code_t CODE_EQUAL = 8'd61;

  // Fixed code of matrix bit row*8+col; zero means no key.
  function automatic code_t key_table(input logic [5:0] idx);
    code_t c;
    c = '0;
    if (idx < 6'd27) begin
      c = code_t'(8'd64 + {2'b00, idx});               // @ A..Z
    end else if (idx == 6'd31) begin
      c = 8'd32;                                        // space
    end else if (idx >= 6'd32 && idx < 6'd44) begin
      c = code_t'(8'd16 + {2'b00, idx});               // 0..9 : ;
    end else if (idx >= 6'd44 && idx < 6'd48) begin
      c = code_t'({2'b00, idx});                        // , - . /
    end
    return c;
  endfunction

  function automatic code_t apply_shift(input code_t c);
    code_t r;
    r = c;
    if (c == CODE_COLON) r = CODE_STAR;
    else if (c == CODE_SEMI) r = CODE_PLUS;
    else if (c == CODE_MINUS) r = CODE_EQUAL;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/keyboard_matrix_scanner.sv =====
// keyboard_matrix_scanner: decodes key matrix snapshots and reports a key on release.
// Depends on kbms_pkg (table, constants, types).
//
//  channel  dir  handshake              payload
//  in       in   in_valid / in_ready    key_matrix[55:0]
//  out      out  out_valid / out_ready  key_code[7:0], entropy[15:0]
//  cfg      in   cfg_write              cfg_index[2:0], cfg_data[7:0]
//
// One snapshot per cycle unless a stalled result blocks the input; a report is valid once its
// snapshot has passed the input register, then the result register.
// The decode (column-major priority pick) and phase update sit between the two.
// Reset (rst, synchronous) clears phase, latched code, counter and valid flags.
// A stalled result holds only the stage ahead of it; the input stage keeps
// filling until it is blocked too.
`default_nettype none

module keyboard_matrix_scanner (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [kbms_pkg::NumKeys-1:0]    key_matrix,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [kbms_pkg::CodeW-1:0]           key_code,
  output logic [kbms_pkg::EntropyW-1:0]        entropy,
  input  wire logic                            cfg_write,
  input  wire logic [kbms_pkg::CfgIdxW-1:0]    cfg_index,
  input  wire logic [kbms_pkg::CodeW-1:0]      cfg_data
);

  localparam logic [1:0] PH_RELEASE = 2'd0;
  localparam logic [1:0] PH_PRESS   = 2'd1;
  localparam logic [1:0] PH_FINAL   = 2'd2;

  kbms_pkg::code_t    code_up, code_down, code_delete, code_return, code_escape;
  logic [1:0]         phase, phase_next;
  kbms_pkg::code_t    latched_code, latched_code_next;
  kbms_pkg::entropy_t entropy_count, entropy_count_next;

  logic               s1_valid;
  kbms_pkg::matrix_t  s1_matrix;
  logic               advance;
  logic               emit;

  kbms_pkg::code_t    key_codes [kbms_pkg::NumKeys];
  kbms_pkg::matrix_t  eligible, first_hot;
  kbms_pkg::code_t    picked, decoded;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      code_up     <= kbms_pkg::RST_UP;
      code_down   <= kbms_pkg::RST_DOWN;
      code_delete <= kbms_pkg::RST_DELETE;
      code_return <= kbms_pkg::RST_RETURN;
      code_escape <= kbms_pkg::RST_ESCAPE;
    end else if (cfg_write) begin
      unique case (cfg_index)
        kbms_pkg::CFG_UP:     code_up     <= cfg_data;
        kbms_pkg::CFG_DOWN:   code_down   <= cfg_data;
        kbms_pkg::CFG_DELETE: code_delete <= cfg_data;
        kbms_pkg::CFG_RETURN: code_return <= cfg_data;
        kbms_pkg::CFG_ESCAPE: code_escape <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_matrix <= key_matrix;
    end
  end

  // per-key codes and eligibility, reordered column-major (col*7+row)
  always_comb begin
    for (int unsigned r = 0; r < kbms_pkg::NumRows; r++) begin
      for (int unsigned c = 0; c < kbms_pkg::NumCols; c++) begin
        key_codes[c*kbms_pkg::NumRows + r] = kbms_pkg::key_table(6'(r*kbms_pkg::NumCols + c));
      end
    end
    key_codes[3*kbms_pkg::NumRows + 3] = code_up;
    key_codes[4*kbms_pkg::NumRows + 3] = code_down;
    key_codes[5*kbms_pkg::NumRows + 3] = code_delete;
    key_codes[0*kbms_pkg::NumRows + 6] = code_return;
    key_codes[2*kbms_pkg::NumRows + 6] = code_escape;
    for (int unsigned r = 0; r < kbms_pkg::NumRows; r++) begin
      for (int unsigned c = 0; c < kbms_pkg::NumCols; c++) begin
        eligible[c*kbms_pkg::NumRows + r] = s1_matrix[r*kbms_pkg::NumCols + c]
            && (key_codes[c*kbms_pkg::NumRows + r] != '0);
      end
    end
  end

  // lowest set bit wins
  assign first_hot = eligible & (~eligible + kbms_pkg::matrix_t'(1));

  always_comb begin
    picked = '0;
    for (int unsigned i = 0; i < kbms_pkg::NumKeys; i++) begin
      picked = picked | (key_codes[i] & {kbms_pkg::CodeW{first_hot[i]}});
    end
    decoded = s1_matrix[kbms_pkg::KEY_SHIFT] ? kbms_pkg::apply_shift(picked) : picked;
  end

  // wait-key phase machine; unused phase behaves as release wait
  always_comb begin
    phase_next         = phase;
    latched_code_next  = latched_code;
    entropy_count_next = entropy_count;
    emit               = 1'b0;
    unique case (phase)
      PH_PRESS: begin
        entropy_count_next = entropy_count + kbms_pkg::entropy_t'(1);
        if (decoded != '0) begin
          latched_code_next = decoded;
          phase_next        = PH_FINAL;
        end
      end
      PH_FINAL: begin
        if (decoded == '0) begin
          emit       = 1'b1;
          phase_next = PH_RELEASE;
        end
      end
      default: begin
        if (decoded != '0) begin
          entropy_count_next = entropy_count + kbms_pkg::entropy_t'(1);
        end else begin
          phase_next = PH_PRESS;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_RELEASE;
      latched_code  <= '0;
      entropy_count <= '0;
    end else if (advance) begin
      phase         <= phase_next;
      latched_code  <= latched_code_next;
      entropy_count <= entropy_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      key_code <= latched_code;
      entropy  <= entropy_count;
    end
  end

`ifndef ASSERT_OFF
  a_code_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> key_code != '0)
    else $error("reported key code is zero");

  a_latched_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_FINAL |-> latched_code != '0)
    else $error("final-release phase without a latched code");

  a_entropy_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (entropy_count == $past(entropy_count))
                 || (entropy_count == kbms_pkg::entropy_t'($past(entropy_count) + 1'b1)))
    else $error("entropy counter moved by more than one");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while both stages are held");
`endif

endmodule

`default_nettype wire

// ===== bench/keyboard_matrix_scanner_tb.sv =====
// keyboard_matrix_scanner_tb: self-checking bench for the key matrix scanner.
// Needs kbms_pkg and keyboard_matrix_scanner; drives snapshots, checks key reports
// against a cycle-free scanner model kept in this file.
`timescale 1ns / 1ps

module keyboard_matrix_scanner_tb;

  localparam int unsigned CLK_HALF        = 5;
  localparam int unsigned RESET_CYCLES    = 6;
  localparam int unsigned ITEMS_PER_PHASE = 270;
  localparam int unsigned NUM_PHASES      = 5;
  localparam int unsigned SETTLE_CYCLES   = 6;
  localparam int unsigned CYCLE_LIMIT     = 200000;

  // symbol keys that shift remaps
  localparam int unsigned BIT_COLON = 42;
  localparam int unsigned BIT_SEMI  = 43;
  localparam int unsigned BIT_MINUS = 45;

  localparam kbms_pkg::matrix_t ONE_KEY  = kbms_pkg::matrix_t'(1);
  localparam kbms_pkg::matrix_t SHIFTED  = ONE_KEY << kbms_pkg::KEY_SHIFT;
  localparam kbms_pkg::matrix_t ALL_DOWN = '1;
  // right arrow, clear, alt, ctrl, f1, f2: all without a code
  localparam kbms_pkg::matrix_t DEAD_KEYS = (ONE_KEY << 30)
                                          | (kbms_pkg::matrix_t'(8'h7A) << 48);

  typedef enum logic [1:0] {
    SCAN_WAIT_RELEASE,
    SCAN_WAIT_PRESS,
    SCAN_WAIT_FINAL
  } scan_phase_e;

  typedef struct packed {
    kbms_pkg::code_t    code;
    kbms_pkg::entropy_t ent;
  } key_report_t;

  typedef struct packed {
    kbms_pkg::matrix_t  snap;
    logic               fixed;
    kbms_pkg::code_t    code;
    kbms_pkg::entropy_t ent;
  } directed_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  kbms_pkg::matrix_t  key_matrix = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  kbms_pkg::code_t    key_code;
  kbms_pkg::entropy_t entropy;
  logic               cfg_write = 1'b0;
  logic [kbms_pkg::CfgIdxW-1:0] cfg_index = '0;
  kbms_pkg::code_t    cfg_data = '0;

  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;

  key_report_t report_q[$];

  // scanner model state
  scan_phase_e        scan_phase = SCAN_WAIT_RELEASE;
  kbms_pkg::code_t    held_code = '0;
  kbms_pkg::entropy_t poll_count = '0;
  kbms_pkg::code_t up_code     = kbms_pkg::RST_UP;
  kbms_pkg::code_t down_code   = kbms_pkg::RST_DOWN;
  kbms_pkg::code_t delete_code = kbms_pkg::RST_DELETE;
  kbms_pkg::code_t return_code = kbms_pkg::RST_RETURN;
  kbms_pkg::code_t escape_code = kbms_pkg::RST_ESCAPE;

  kbms_pkg::code_t fixed_code [kbms_pkg::NumKeys] = '{
    8'd64, 8'd65, 8'd66, 8'd67, 8'd68, 8'd69, 8'd70, 8'd71,
    8'd72, 8'd73, 8'd74, 8'd75, 8'd76, 8'd77, 8'd78, 8'd79,
    8'd80, 8'd81, 8'd82, 8'd83, 8'd84, 8'd85, 8'd86, 8'd87,
    8'd88, 8'd89, 8'd90, 8'd0,  8'd0,  8'd0,  8'd0,  8'd32,
    8'd48, 8'd49, 8'd50, 8'd51, 8'd52, 8'd53, 8'd54, 8'd55,
    8'd56, 8'd57, 8'd58, 8'd59, 8'd44, 8'd45, 8'd46, 8'd47,
    8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0
  };

  // Typed entries follow press/release triplets from reset; entropy counts polls.
  directed_row_t directed_rows [29] = '{
    '{'0, 1'b0, 8'd0, 16'd0},
    '{ONE_KEY << 1, 1'b0, 8'd0, 16'd0},                       // A
    '{'0, 1'b1, 8'd65, 16'd1},
    '{'0, 1'b0, 8'd0, 16'd0},
    '{ONE_KEY << kbms_pkg::KEY_UP, 1'b0, 8'd0, 16'd0},
    '{'0, 1'b1, kbms_pkg::RST_UP, 16'd2},
    '{'0, 1'b0, 8'd0, 16'd0},
    '{ALL_DOWN, 1'b0, 8'd0, 16'd0},
    '{ALL_DOWN, 1'b0, 8'd0, 16'd0},                           // still held
    '{'0, 1'b1, 8'd64, 16'd3},
    '{'0, 1'b0, 8'd0, 16'd0},
    '{SHIFTED, 1'b0, 8'd0, 16'd0},                            // modifier alone
    '{SHIFTED | (ONE_KEY << BIT_COLON), 1'b0, 8'd0, 16'd0},
    '{'0, 1'b1, kbms_pkg::CODE_STAR, 16'd5},
    '{'0, 1'b0, 8'd0, 16'd0},
    '{DEAD_KEYS, 1'b0, 8'd0, 16'd0},
    '{SHIFTED | (ONE_KEY << BIT_SEMI) | (ONE_KEY << BIT_MINUS), 1'b0, 8'd0, 16'd0},
    '{'0, 1'b1, kbms_pkg::CODE_PLUS, 16'd7},
    '{'0, 1'b0, 8'd0, 16'd0},
    '{(ONE_KEY << 9) | (ONE_KEY << 16), 1'b0, 8'd0, 16'd0},   // column 0 wins
    '{'0, 1'b0, 8'd0, 16'd0},
    '{ONE_KEY << kbms_pkg::KEY_RETURN, 1'b0, 8'd0, 16'd0},    // held from release wait
    '{'0, 1'b0, 8'd0, 16'd0},
    '{ONE_KEY << kbms_pkg::KEY_ESCAPE, 1'b0, 8'd0, 16'd0},
    '{'0, 1'b0, 8'd0, 16'd0},
    '{ONE_KEY << kbms_pkg::KEY_DELETE, 1'b0, 8'd0, 16'd0},
    '{'0, 1'b0, 8'd0, 16'd0},
    '{SHIFTED | (ONE_KEY << BIT_MINUS), 1'b0, 8'd0, 16'd0},
    '{'0, 1'b0, 8'd0, 16'd0}
  };

  keyboard_matrix_scanner dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .key_matrix (key_matrix),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .key_code   (key_code),
    .entropy    (entropy),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #(CLK_HALF) clk = ~clk;

  function automatic kbms_pkg::code_t lookup_code(input int unsigned idx);
    case (idx)
      kbms_pkg::KEY_UP:     return up_code;
      kbms_pkg::KEY_DOWN:   return down_code;
      kbms_pkg::KEY_DELETE: return delete_code;
      kbms_pkg::KEY_RETURN: return return_code;
      kbms_pkg::KEY_ESCAPE: return escape_code;
      default:              return fixed_code[idx];
    endcase
  endfunction

  // column-major scan, first key with a nonzero code
  function automatic kbms_pkg::code_t decode_snapshot(input kbms_pkg::matrix_t m);
    kbms_pkg::code_t c;
    int unsigned idx;
    for (int unsigned col = 0; col < kbms_pkg::NumCols; col++) begin
      for (int unsigned row = 0; row < kbms_pkg::NumRows; row++) begin
        idx = row * kbms_pkg::NumCols + col;
        if (m[idx]) begin
          c = lookup_code(idx);
          if (c != '0) begin
            if (m[kbms_pkg::KEY_SHIFT]) begin
              case (c)
                kbms_pkg::CODE_COLON: c = kbms_pkg::CODE_STAR;
                kbms_pkg::CODE_SEMI:  c = kbms_pkg::CODE_PLUS;
                kbms_pkg::CODE_MINUS: c = kbms_pkg::CODE_EQUAL;
                default: ;
              endcase
            end
            return c;
          end
        end
      end
    end
    return '0;
  endfunction

  function automatic bit scan_step(input kbms_pkg::matrix_t m, output key_report_t r);
    kbms_pkg::code_t c;
    c = decode_snapshot(m);
    r = '0;
    case (scan_phase)
      SCAN_WAIT_PRESS: begin
        poll_count = poll_count + 1'b1;
        if (c != '0) begin
          held_code = c;
          scan_phase = SCAN_WAIT_FINAL;
        end
        return 1'b0;
      end
      SCAN_WAIT_FINAL: begin
        if (c == '0) begin
          r.code = held_code;
          r.ent = poll_count;
          scan_phase = SCAN_WAIT_RELEASE;
          return 1'b1;
        end
        return 1'b0;
      end
      default: begin
        if (c != '0) poll_count = poll_count + 1'b1;
        else scan_phase = SCAN_WAIT_PRESS;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic void set_code_reg(input logic [kbms_pkg::CfgIdxW-1:0] idx,
                                       input kbms_pkg::code_t d);
    case (idx)
      kbms_pkg::CFG_UP:     up_code = d;
      kbms_pkg::CFG_DOWN:   down_code = d;
      kbms_pkg::CFG_DELETE: delete_code = d;
      kbms_pkg::CFG_RETURN: return_code = d;
      kbms_pkg::CFG_ESCAPE: escape_code = d;
      default: ;
    endcase
  endfunction

  function automatic kbms_pkg::matrix_t random_press();
    kbms_pkg::matrix_t m;
    int unsigned sel;
    m = '0;
    sel = $urandom_range(0, 9);
    if (sel < 5) begin
      m[$urandom_range(0, kbms_pkg::NumKeys - 1)] = 1'b1;
    end else if (sel == 5) begin
      m[kbms_pkg::KEY_SHIFT] = 1'b1;
      case ($urandom_range(0, 2))
        0: m[BIT_COLON] = 1'b1;
        1: m[BIT_SEMI] = 1'b1;
        default: m[BIT_MINUS] = 1'b1;
      endcase
    end else if (sel == 6) begin
      m[$urandom_range(0, kbms_pkg::NumKeys - 1)] = 1'b1;
      m[kbms_pkg::KEY_SHIFT] = 1'b1;
    end else if (sel < 9) begin
      repeat ($urandom_range(2, 4)) m[$urandom_range(0, kbms_pkg::NumKeys - 1)] = 1'b1;
    end else begin
      m = kbms_pkg::matrix_t'({$urandom, $urandom});
    end
    return m;
  endfunction

  // Present one snapshot; on acceptance advance the model and queue its report.
  task automatic send_snapshot(input kbms_pkg::matrix_t m, input bit fixed,
                               input key_report_t fixed_r);
    key_report_t r;
    bit has_r;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    key_matrix <= m;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    has_r = scan_step(m, r);
    if (fixed) report_q.push_back(fixed_r);
    else if (has_r) report_q.push_back(r);
  endtask

  task automatic write_reg(input logic [kbms_pkg::CfgIdxW-1:0] idx,
                           input kbms_pkg::code_t d);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    set_code_reg(idx, d);
  endtask

  // Drain, let the pipe empty, then load the code registers for this phase.
  task automatic reconfigure(input int unsigned ph);
    kbms_pkg::code_t d;
    in_valid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    for (int i = kbms_pkg::CFG_UP; i <= kbms_pkg::CFG_ESCAPE; i++) begin
      if (ph == 1) d = 8'hFF;
      else if (ph == 2) d = 8'h00;
      else d = kbms_pkg::code_t'($urandom_range(0, 255));
      write_reg(i[kbms_pkg::CfgIdxW-1:0], d);
    end
    // indexes past the last register must be ignored
    if (ph == 1) begin
      for (int i = kbms_pkg::CFG_ESCAPE + 1; i < (1 << kbms_pkg::CfgIdxW); i++) begin
        write_reg(i[kbms_pkg::CfgIdxW-1:0], kbms_pkg::code_t'($urandom_range(0, 255)));
      end
    end
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    key_report_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (report_q.size() == 0) begin
          $error("unexpected key report: key_code %0d entropy %0d", key_code, entropy);
          error_count++;
        end else begin
          want = report_q.pop_front();
          if (key_code !== want.code) begin
            $error("key_code mismatch: expected %0d, actual %0d", want.code, key_code);
            error_count++;
          end
          if (entropy !== want.ent) begin
            $error("entropy mismatch: expected %0d, actual %0d", want.ent, entropy);
            error_count++;
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    directed_row_t row;
    key_report_t fixed_r;
    kbms_pkg::matrix_t press;
    int unsigned sent;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      fixed_r.code = row.code;
      fixed_r.ent = row.ent;
      send_snapshot(row.snap, row.fixed, fixed_r);
    end

    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph != 0) reconfigure(ph);
      case (ph)
        1: begin send_idle_pct = 62; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 62; end
        3: begin send_idle_pct = 23; stall_pct = 23; end
        default: begin send_idle_pct = 0; stall_pct = 0; end
      endcase
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 9) < 8) begin
          // release, press (possibly changing while held), release
          repeat ($urandom_range(1, 2)) begin
            send_snapshot('0, 1'b0, '0);
            sent++;
          end
          press = random_press();
          repeat ($urandom_range(1, 3)) begin
            send_snapshot(press, 1'b0, '0);
            if ($urandom_range(0, 3) == 0) press = random_press();
            sent++;
          end
          repeat ($urandom_range(1, 2)) begin
            send_snapshot('0, 1'b0, '0);
            sent++;
          end
        end else begin
          repeat ($urandom_range(1, 4)) begin
            send_snapshot(kbms_pkg::matrix_t'({$urandom, $urandom}), 1'b0, '0);
            sent++;
          end
        end
      end
    end

    in_valid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
